[hdl/pee_pkg.sv]
package pee_pkg;

	localparam int StackDepth = 128;
	localparam int PtrW = $clog2(StackDepth);
	localparam int CntW = $clog2(StackDepth + 1);

	localparam logic [7:0] ChSpace = 8'd32;
	localparam logic [7:0] ChZero = 8'd48;
	localparam logic [7:0] ChNine = 8'd57;
	localparam logic [7:0] OpMul = 8'd42;
	localparam logic [7:0] OpAdd = 8'd43;
	localparam logic [7:0] OpSub = 8'd45;
	localparam logic [7:0] OpDiv = 8'd47;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               overflow;
		logic               underflow;
		logic               div_zero;
	} out_item_t;

	// Datapath commands issued by the controller.
	typedef struct packed {
		logic       load;      // capture input item
		logic       accum;     // update number accumulator
		logic       push_num;  // push accumulator
		logic       pop_rd;    // issue pop read
		logic       take_x;    // latch popped value into x
		logic       take_y;    // latch popped value into y
		logic       div_start;
		logic       push_res;  // push operator result
		logic       final_pop; // latch popped value as result
		logic       clear;     // empty stack, clear accumulator and flags
	} cmd_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       in_number;
		logic       div_busy;
	} sts_t;

endpackage

[hdl/pee_divider.sv]
module pee_divider
	import pee_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] quotient
);

	logic [31:0] rem_q, quo_q, den_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic        busy_q;
	logic [32:0] trial;
	logic [31:0] shifted;

	assign shifted = {rem_q[30:0], quo_q[31]};
	assign trial = {1'b0, shifted} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? (~dividend + 32'd1) : dividend;
			den_q <= divisor[31] ? (~divisor + 32'd1) : divisor;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quotient = neg_q ? (~quo_q + 32'd1) : quo_q;

endmodule

[hdl/pee_datapath.sv]
module pee_datapath
	import pee_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_item,
	input  cmd_t      cmd,
	output sts_t      sts,
	output out_item_t result
);

	logic [31:0]   mem [StackDepth];
	logic [CntW-1:0] cnt_q;
	logic [31:0]   accum_q, x_q, y_q, rd_q, res_v, quo;
	logic          in_num_q, ovf_q, unf_q, dz_q, empty_q;
	logic [7:0]    ch_q;
	logic          last_q;
	logic          div_busy;
	logic          push, full;
	logic [31:0]   push_data, popped;
	logic          x_zero;

	assign full = (cnt_q == CntW'(StackDepth));
	assign push = cmd.push_num | cmd.push_res;
	assign x_zero = (x_q == 32'd0);
	assign popped = empty_q ? 32'hFFFF_FFFF : rd_q;

	always_comb begin
		case (ch_q)
			OpMul: res_v = y_q * x_q;
			OpAdd: res_v = y_q + x_q;
			OpSub: res_v = y_q - x_q;
			OpDiv: res_v = x_zero ? 32'd0 : quo;
			default: res_v = y_q;
		endcase
	end

	assign push_data = cmd.push_res ? res_v : accum_q;

	pee_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(y_q), .divisor(x_q), .busy(div_busy), .quotient(quo)
	);

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem[cnt_q[PtrW-1:0]] <= push_data;
		end
		if (cmd.pop_rd) begin
			rd_q <= mem[PtrW'(cnt_q - CntW'(1))];
		end
		if (cmd.load) begin
			ch_q <= in_item.ch;
			last_q <= in_item.last;
		end
		if (cmd.take_x) x_q <= popped;
		if (cmd.take_y) y_q <= popped;
		if (cmd.final_pop) begin
			result.value <= popped;
			result.overflow <= ovf_q;
			result.underflow <= unf_q;
			result.div_zero <= dz_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			accum_q <= '0;
			in_num_q <= 1'b0;
			ovf_q <= 1'b0;
			unf_q <= 1'b0;
			dz_q <= 1'b0;
			empty_q <= 1'b0;
		end else if (cmd.clear) begin
			cnt_q <= '0;
			accum_q <= '0;
			in_num_q <= 1'b0;
			ovf_q <= 1'b0;
			unf_q <= 1'b0;
			dz_q <= 1'b0;
		end else begin
			if (cmd.accum) begin
				if (in_num_q) begin
					accum_q <= accum_q * 32'd10 + {24'd0, ch_q} - {24'd0, ChZero};
				end else begin
					accum_q <= {24'd0, ch_q} - {24'd0, ChZero};
					in_num_q <= 1'b1;
				end
			end
			if (cmd.push_num) begin
				accum_q <= '0;
				in_num_q <= 1'b0;
			end
			if (push) begin
				if (full) ovf_q <= 1'b1;
				else cnt_q <= cnt_q + CntW'(1);
			end
			if (cmd.pop_rd) begin
				empty_q <= (cnt_q == '0);
				if (cnt_q == '0) unf_q <= 1'b1;
				else cnt_q <= cnt_q - CntW'(1);
			end
			if (cmd.push_res && ch_q == OpDiv && x_zero) begin
				dz_q <= 1'b1;
			end
		end
	end

	assign sts.ch = ch_q;
	assign sts.last = last_q;
	assign sts.in_number = in_num_q;
	assign sts.div_busy = div_busy;

	property p_no_grow_past_depth;
		@(posedge clk) disable iff (!arst_n) cnt_q <= CntW'(StackDepth);
	endproperty
	a_no_grow_past_depth: assert property (p_no_grow_past_depth) else $error("stack count");

	property p_clear_empties;
		@(posedge clk) disable iff (!arst_n) cmd.clear |=> (cnt_q == '0 && !in_num_q);
	endproperty
	a_clear_empties: assert property (p_clear_empties) else $error("clear");

	property p_one_stack_op;
		@(posedge clk) disable iff (!arst_n) !(push && cmd.pop_rd);
	endproperty
	a_one_stack_op: assert property (p_one_stack_op) else $error("push and pop");

endmodule

[hdl/pee_ctrl.sv]
module pee_ctrl
	import pee_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_POPX  = 4'd2;
	localparam logic [3:0] S_TAKEX = 4'd3;
	localparam logic [3:0] S_TAKEY = 4'd4;
	localparam logic [3:0] S_DIV   = 4'd5;
	localparam logic [3:0] S_DIVW  = 4'd6;
	localparam logic [3:0] S_PUSH  = 4'd7;
	localparam logic [3:0] S_END   = 4'd8;
	localparam logic [3:0] S_FPOP  = 4'd9;
	localparam logic [3:0] S_FTAKE = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       is_digit;

	assign is_digit = (sts.ch >= ChZero) && (sts.ch <= ChNine);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.ch == ChSpace) begin
					cmd.push_num = sts.in_number;
					state_d = S_END;
				end else if (sts.in_number || is_digit) begin
					cmd.accum = 1'b1;
					state_d = S_END;
				end else begin
					cmd.pop_rd = 1'b1;
					state_d = S_POPX;
				end
			end
			S_POPX: begin
				cmd.take_x = 1'b1;
				cmd.pop_rd = 1'b1;
				state_d = S_TAKEX;
			end
			S_TAKEX: begin
				cmd.take_y = 1'b1;
				state_d = (sts.ch == OpDiv) ? S_DIV : S_PUSH;
			end
			S_TAKEY: state_d = S_PUSH;
			S_DIV: begin
				cmd.div_start = 1'b1;
				state_d = S_DIVW;
			end
			S_DIVW: if (!sts.div_busy) state_d = S_PUSH;
			S_PUSH: begin
				cmd.push_res = 1'b1;
				state_d = S_END;
			end
			S_END: begin
				if (!sts.last) begin
					state_d = S_IDLE;
				end else begin
					cmd.push_num = sts.in_number;
					state_d = S_FPOP;
				end
			end
			S_FPOP: begin
				cmd.pop_rd = 1'b1;
				state_d = S_FTAKE;
			end
			S_FTAKE: begin
				cmd.final_pop = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					cmd.clear = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= (state_d == S_OUT);
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	property p_valid_in_out;
		@(posedge clk) disable iff (!arst_n) out_valid |-> state_q == S_OUT;
	endproperty
	a_valid_in_out: assert property (p_valid_in_out) else $error("out_valid");

	property p_div_wait;
		@(posedge clk) disable iff (!arst_n) state_q == S_DIV |=> sts.div_busy;
	endproperty
	a_div_wait: assert property (p_div_wait) else $error("divider");

	property p_load_idle;
		@(posedge clk) disable iff (!arst_n) cmd.load |-> !in_stall;
	endproperty
	a_load_idle: assert property (p_load_idle) else $error("load");

endmodule

[hdl/postfix_expression_evaluator_unit.sv]
// Postfix evaluator: takes one ASCII character per item and, on the item marked
// last, delivers the popped final value with overflow, underflow and divide by
// zero flags, then clears itself. A digit or space is decoded and done; an operator
// pops its two operands and pushes the result, and a division first waits for the
// divider, which makes one quotient bit per cycle. The stack is a 128-entry memory.
module postfix_expression_evaluator_unit
	import pee_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	cmd_t cmd;
	sts_t sts;

	pee_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	pee_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .cmd(cmd), .sts(sts),
		.result(out_item)
	);

endmodule
